// ----- rtl/core/lpm_pkg.sv -----
`default_nettype none

package lpm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int HOP_WIDTH   = 16;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [5:0] MAX_LENGTH = 6'd32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] insert_prefix;
    logic [5:0]  insert_length;
    logic [15:0] insert_hop;
    logic [31:0] lookup_address;
  } lpm_req_t;

  typedef struct packed {
    logic [15:0] result_hop;
    logic        hit;
    logic [5:0]  matched_length;
    logic [1:0]  status;
  } lpm_rsp_t;

  typedef struct packed {
    logic [31:0]          prefix;
    logic [5:0]           length;
    logic [HOP_WIDTH-1:0] hop;
  } lpm_entry_t;

  localparam int ENTRY_W = $bits(lpm_entry_t);

  // Running winner of a scan.
  typedef struct packed {
    logic                 hit;
    logic [5:0]           length;
    logic [HOP_WIDTH-1:0] hop;
  } lpm_best_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpm_ram.sv -----
`default_nettype none

module lpm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lpm_match.sv -----
`default_nettype none

module lpm_match (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               en,
  input  wire logic [31:0]        address,
  input  wire lpm_pkg::lpm_entry_t entry,
  output lpm_pkg::lpm_best_t      best
);
  import lpm_pkg::*;

  logic [31:0] mask;
  logic        match;
  logic        better;

  // A shift by the full 32 bits leaves an empty mask, which is the default route.
  assign mask   = 32'hFFFF_FFFF << (MAX_LENGTH - entry.length);
  assign match  = ((entry.prefix & mask) == (address & mask));
  assign better = !best.hit || (entry.length > best.length);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      best.hit    <= 1'b0;
      best.length <= '0;
      best.hop    <= '0;
    end else if (en && match && better) begin
      best.hit    <= 1'b1;
      best.length <= entry.length;
      best.hop    <= entry.hop;
    end
  end

  a_best_len_range: assert property (@(posedge clk) disable iff (rst)
    best.length <= MAX_LENGTH)
    else $error("winning length beyond 32");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    !best.hit |-> (best.length == '0 && best.hop == '0))
    else $error("miss carries a stale winner");

  a_hit_sticks: assert property (@(posedge clk) disable iff (rst)
    (best.hit && !start) |=> best.hit)
    else $error("hit lost during a scan");

endmodule

`default_nettype wire

// ----- rtl/core/longest_prefix_match_table.sv -----
// IPv4 longest-prefix-match route table.
// Requests arrive on req (valid/ready) and each gives exactly one response on
// rsp (valid/ready). An insert appends a prefix, length and next hop; a lookup
// returns the next hop of the longest matching prefix, earlier entries winning
// ties; a clear empties the table; the unused action code returns all zeros.
// An insert or clear is written into the table at acceptance, and its
// response is loaded into the output register once that register is free.
// A lookup reads the stored entries from the table memory one entry per cycle
// through the shared compare unit; the scan state is followed by the drain
// state, which waits for the last read data, and then the done state, where
// the response is loaded once the output register is free.
// A lookup on an empty table reads nothing and goes straight to the done
// state, as an insert does.
// req_ready is high only while the sequencer is idle. The output register lets
// the next request be accepted while a response still waits; a new response
// is held back in the sequencer until the receiver has taken the previous one.
// Reset empties the table at once (the entry count is cleared; no clearing
// pass is needed) and drops any pending response.
`default_nettype none

module longest_prefix_match_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire lpm_pkg::lpm_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output lpm_pkg::lpm_rsp_t      rsp
);
  import lpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t            state;
  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   scan_idx;
  logic               rd_pending;
  logic               is_lookup;
  logic [31:0]        address;
  lpm_rsp_t           pend;

  logic       accept;
  logic       bad_len;
  logic       full;
  logic       wr_en;
  logic       rd_en;
  logic       last_read;
  logic       start;
  logic       rsp_load;
  lpm_entry_t wr_entry;
  lpm_entry_t rd_entry;
  lpm_best_t  best;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign bad_len   = req.insert_length > MAX_LENGTH;
  assign full      = (count == COUNT_W'(TABLE_DEPTH));
  assign wr_en     = accept && (req.action == ACT_INSERT) && !bad_len && !full;
  assign rd_en     = (state == S_SCAN);
  assign last_read = ((COUNT_W'(scan_idx) + COUNT_W'(1)) == count);
  assign start     = accept && (req.action == ACT_LOOKUP);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign wr_entry.prefix = req.insert_prefix;
  assign wr_entry.length = req.insert_length;
  assign wr_entry.hop    = HOP_WIDTH'(req.insert_hop);

  lpm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[IDX_W-1:0]),
    .wr_data(wr_entry),
    .rd_en  (rd_en),
    .rd_addr(scan_idx),
    .rd_data(rd_entry)
  );

  lpm_match u_match (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .en     (rd_pending),
    .address(address),
    .entry  (rd_entry),
    .best   (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      scan_idx   <= '0;
      rd_pending <= 1'b0;
      is_lookup  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_pending <= (state == S_SCAN);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_lookup           <= (req.action == ACT_LOOKUP);
            address             <= req.lookup_address;
            scan_idx            <= '0;
            pend.result_hop     <= '0;
            pend.hit            <= 1'b0;
            pend.matched_length <= '0;
            unique case (req.action)
              ACT_INSERT: begin
                if (bad_len) begin
                  pend.status <= STATUS_BAD_LEN;
                end else if (full) begin
                  pend.status <= STATUS_FULL;
                end else begin
                  pend.status <= STATUS_OK;
                  count       <= count + COUNT_W'(1);
                end
                state <= S_DONE;
              end
              ACT_LOOKUP: begin
                pend.status <= STATUS_OK;
                state       <= (count == '0) ? S_DONE : S_SCAN;
              end
              ACT_CLEAR: begin
                pend.status <= STATUS_OK;
                count       <= '0;
                state       <= S_DONE;
              end
              default: begin
                pend.status <= STATUS_OK;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (last_read) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            if (is_lookup) begin
              rsp.result_hop     <= 16'(best.hop);
              rsp.hit            <= best.hit;
              rsp.matched_length <= best.length;
              rsp.status         <= STATUS_OK;
            end else begin
              rsp <= pend;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (COUNT_W'(scan_idx) < count))
    else $error("scan reads an entry that was never written");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + COUNT_W'(1)))
    else $error("stored insert did not advance the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_CLEAR) |=> (count == '0))
    else $error("clear left entries in the table");

  a_lookup_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && is_lookup && (!rsp_valid || rsp_ready)) |=>
      (rsp_valid && rsp.status == STATUS_OK && rsp.hit == $past(best.hit)))
    else $error("lookup response not taken from the compare unit");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lpm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int SESSION_MAX_ROUTES = 24;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lpm_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lpm_rsp_t rsp;

  // Shadow copy of the route table, updated as each request is accepted.
  logic [31:0]          route_prefix [TABLE_DEPTH];
  logic [5:0]           route_len    [TABLE_DEPTH];
  logic [HOP_WIDTH-1:0] route_hop    [TABLE_DEPTH];
  int                   route_count = 0;

  lpm_rsp_t replies_due [$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       quiet_cycles = 0;

  longest_prefix_match_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] prefix_mask(logic [5:0] len);
    if (len == 6'd0) begin
      return 32'h0;
    end
    return 32'hFFFF_FFFF << (6'd32 - len);
  endfunction

  function automatic lpm_rsp_t apply_route_request(lpm_req_t r);
    lpm_rsp_t    reply;
    int          best;
    logic [31:0] m;
    reply = '0;
    best = -1;
    case (r.action)
      ACT_INSERT: begin
        // The length check takes priority over the full check.
        if (r.insert_length > MAX_LENGTH) begin
          reply.status = STATUS_BAD_LEN;
        end else if (route_count >= TABLE_DEPTH) begin
          reply.status = STATUS_FULL;
        end else begin
          route_prefix[route_count] = r.insert_prefix;
          route_len[route_count]    = r.insert_length;
          route_hop[route_count]    = r.insert_hop[HOP_WIDTH-1:0];
          route_count++;
        end
      end
      ACT_LOOKUP: begin
        for (int i = 0; i < route_count; i++) begin
          m = prefix_mask(route_len[i]);
          if ((((route_prefix[i] ^ r.lookup_address) & m) == 32'h0) &&
              (int'(route_len[i]) > best)) begin
            best = int'(route_len[i]);
            reply.result_hop = 16'(route_hop[i]);
          end
        end
        if (best >= 0) begin
          reply.hit = 1'b1;
          reply.matched_length = 6'(best);
        end
      end
      ACT_CLEAR: begin
        route_count = 0;
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic lpm_req_t make_req(logic [1:0] action, logic [31:0] pfx,
                                        logic [5:0] len, logic [15:0] hop,
                                        logic [31:0] addr);
    lpm_req_t r;
    r.action         = action;
    r.insert_prefix  = pfx;
    r.insert_length  = len;
    r.insert_hop     = hop;
    r.lookup_address = addr;
    return r;
  endfunction

  // Valid is only lowered when a gap is wanted, so it is never dropped and raised
  // again within one time step.
  task automatic send_request(lpm_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    replies_due = {replies_due, apply_route_request(item)};
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic lpm_req_t random_insert();
    lpm_req_t r;
    int       pick;
    int       idx;
    r = make_req(ACT_INSERT, $urandom, 6'($urandom_range(1, 31)), 16'($urandom), $urandom);
    pick = $urandom_range(99);
    if (pick < 6) begin
      r.insert_length = 6'($urandom_range(63, 33));
    end else if (pick < 12) begin
      r.insert_length = ($urandom_range(1) == 0) ? 6'd0 : 6'd32;
    end else if (pick < 22 && route_count > 0) begin
      // Same length and prefix as a stored route, so the earlier one must win.
      idx = $urandom_range(route_count - 1);
      r.insert_length = route_len[idx];
      r.insert_prefix = (route_prefix[idx] & prefix_mask(route_len[idx])) |
                        ($urandom & ~prefix_mask(route_len[idx]));
    end
    return r;
  endfunction

  function automatic lpm_req_t random_lookup();
    lpm_req_t    r;
    int          idx;
    logic [31:0] m;
    r = make_req(ACT_LOOKUP, $urandom, 6'($urandom_range(63)), 16'($urandom), $urandom);
    if (route_count > 0 && $urandom_range(99) < 60) begin
      idx = $urandom_range(route_count - 1);
      m = prefix_mask(route_len[idx]);
      r.lookup_address = (route_prefix[idx] & m) | ($urandom & ~m);
      // Now and then flip one bit inside the prefix to land just beside the route.
      if (route_len[idx] != 6'd0 && $urandom_range(3) == 0) begin
        r.lookup_address[31 - $urandom_range(route_len[idx] - 1)] ^= 1'b1;
      end
    end
    return r;
  endfunction

  task automatic test_directed_routes();
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0000_0000));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'hFFFF_FFFF));
    send_request(make_req(ACT_UNUSED, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_req(ACT_CLEAR, 32'h0, 6'd0, 16'h0, 32'h0));
    send_request(make_req(ACT_INSERT, 32'h0A00_0000, 6'd33, 16'h1234, 32'h0));
    send_request(make_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'h0));
    // Bits below the prefix length must not take part in the match.
    send_request(make_req(ACT_INSERT, 32'h0A12_3456, 6'd8, 16'h000A, 32'h0));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0AFF_FFFF));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0B00_0000));
    send_request(make_req(ACT_INSERT, 32'hDEAD_BEEF, 6'd0, 16'h0001, 32'h0));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0B00_0000));
    send_request(make_req(ACT_INSERT, 32'h0A01_0000, 6'd16, 16'h0102, 32'h0));
    send_request(make_req(ACT_INSERT, 32'h0A01_FFFF, 6'd16, 16'h0BAD, 32'h0));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0A01_ABCD));
    send_request(make_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 32'h0));
    send_request(make_req(ACT_INSERT, 32'h0000_0000, 6'd32, 16'h0000, 32'h0));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'hFFFF_FFFF));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'hFFFF_FFFE));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0000_0000));
    send_request(make_req(ACT_INSERT, 32'h8000_0000, 6'd1, 16'h8001, 32'h0));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'hC000_0000));
    send_request(make_req(ACT_CLEAR, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_req(ACT_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0A01_ABCD));
  endtask

  task automatic test_table_full();
    send_request(make_req(ACT_CLEAR, $urandom, 6'($urandom_range(63)), 16'($urandom),
                          $urandom));
    repeat (TABLE_DEPTH) begin
      send_request(make_req(ACT_INSERT, $urandom, 6'($urandom_range(32)), 16'($urandom),
                            $urandom));
    end
    send_request(make_req(ACT_INSERT, $urandom, 6'($urandom_range(32)), 16'($urandom),
                          $urandom));
    // A bad length on a full table still reports the length error.
    send_request(make_req(ACT_INSERT, $urandom, 6'($urandom_range(63, 33)), 16'($urandom),
                          $urandom));
    repeat (3) send_request(random_lookup());
    send_request(make_req(ACT_CLEAR, $urandom, 6'($urandom_range(63)), 16'($urandom),
                          $urandom));
    send_request(random_lookup());
    send_request(random_insert());
    send_request(random_lookup());
  endtask

  task automatic test_route_sessions(int n_items);
    int pick;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_request(make_req(2'($urandom_range(3)), $urandom, 6'($urandom_range(63)),
                              16'($urandom), $urandom));
      end else if (pick < 12) begin
        send_request(make_req(ACT_CLEAR, $urandom, 6'($urandom_range(63)), 16'($urandom),
                              $urandom));
      end else if (pick < 45 && route_count < SESSION_MAX_ROUTES) begin
        send_request(random_insert());
      end else begin
        send_request(random_lookup());
      end
    end
  endtask

  always @(posedge clk) begin
    lpm_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (replies_due.size() == 0) begin
        $error("response with no request outstanding: %h", rsp);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        if (rsp.result_hop !== want.result_hop) begin
          $error("result_hop: expected %0h, actual %0h", want.result_hop, rsp.result_hop);
          fail_count++;
        end
        if (rsp.hit !== want.hit) begin
          $error("hit: expected %0h, actual %0h", want.hit, rsp.hit);
          fail_count++;
        end
        if (rsp.matched_length !== want.matched_length) begin
          $error("matched_length: expected %0d, actual %0d", want.matched_length,
                 rsp.matched_length);
          fail_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          fail_count++;
        end
      end
    end
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(35, 73);
    test_directed_routes();
    test_route_sessions(100);

    set_idling(73, 35);
    test_table_full();
    test_route_sessions(100);

    set_idling(0, 0);
    test_route_sessions(61);

    @(posedge clk);
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lpm_pkg.sv
rtl/core/lpm_ram.sv
rtl/core/lpm_match.sv
rtl/core/longest_prefix_match_table.sv
tb/tb_top.sv
